[rtl/scc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg : shared definitions for the SCC query block
// Default capacities, item codes, status codes and register map.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;

    // configuration register: raw width, reset value, map
    localparam int CFG_W        = 11;
    localparam int NV_RESET     = 1024;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam bit REG_NUM_VERT = 1'b0;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_VERT = 2'd2;

endpackage

[rtl/scc_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_engine : edge store, adjacency build and two-pass DFS sequencer
// One sequencer drives all memories; one step per cycle.
// ----------------------------------------------------------------------------
module scc_engine
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    localparam int VW  = $clog2(MAX_VERTICES),
    localparam int NW  = $clog2(MAX_VERTICES + 1),
    localparam int EW  = $clog2(MAX_EDGES + 1),
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    mode,
    input  logic [VW-1:0] vertex_a,
    input  logic [VW-1:0] vertex_b,
    input  logic [NW-1:0] n_total,
    input  logic          graph_clear,
    output logic          busy,
    output logic          done,
    output logic          connected,
    output logic [1:0]    status
);

    typedef enum logic [4:0] {
        S_IDLE, S_OCLR, S_CNT_RD, S_CNT_OFF, S_CNT_WR, S_PFX_RD, S_PFX_WR,
        S_FIL_RD, S_FIL_OFF, S_FIL_WR, S_VCLR, S_SCAN, S_SFIN, S_SCHK,
        S_OFA, S_OFB, S_STEP, S_NBR, S_VIS, S_POP, S_Q_RDA, S_Q_RDB, S_Q_CMP
    } state_t;

    localparam int SW = VW + EW;

    state_t        state_reg, state_next;
    logic [EW-1:0] ec_reg, ec_next;
    logic          ready_reg, ready_next;
    logic          pass_reg, pass_next;
    logic [EW-1:0] e_idx_reg, e_idx_next;
    logic [NW-1:0] v_idx_reg, v_idx_next;
    logic [EW-1:0] fsum_reg, fsum_next, rsum_reg, rsum_next;
    logic [NW-1:0] fin_reg, fin_next, lbl_reg, lbl_next, depth_reg, depth_next;
    logic [VW-1:0] root_reg, root_next, cur_v_reg, cur_v_next, w_reg, w_next;
    logic [EW-1:0] cur_pos_reg, cur_pos_next, cur_end_reg, cur_end_next;
    logic [VW-1:0] qa_reg, qa_next, qb_reg, qb_next, la_reg, la_next;
    logic          done_reg, done_next, conn_reg, conn_next;
    logic [1:0]    status_reg, status_next;

    // memories
    logic [VW-1:0] esrc_mem [MAX_EDGES];
    logic [VW-1:0] etgt_mem [MAX_EDGES];
    logic [EW-1:0] foff_mem [MAX_VERTICES + 1];
    logic [EW-1:0] roff_mem [MAX_VERTICES + 1];
    logic [VW-1:0] fnbr_mem [MAX_EDGES];
    logic [VW-1:0] rnbr_mem [MAX_EDGES];
    logic          vis_mem  [MAX_VERTICES];
    logic [VW-1:0] fin_mem  [MAX_VERTICES];
    logic [VW-1:0] lab_mem  [MAX_VERTICES];
    logic [SW-1:0] stk_mem  [MAX_VERTICES];

    logic e_we, e_re, fo_we, fo_re, ro_we, ro_re, nb_we, nb_re;
    logic vs_we, vs_re, fn_we, fn_re, lb_we, lb_re, sk_we, sk_re;
    logic [EAW-1:0] e_wa, e_ra, fn_wa, rn_wa, nb_ra;
    logic [VW-1:0]  e_wsrc, e_wtgt, fn_wd, rn_wd;
    logic [NW-1:0]  fo_wa, fo_ra, ro_wa, ro_ra;
    logic [EW-1:0]  fo_wd, ro_wd;
    logic [VW-1:0]  vs_wa, vs_ra, fnw_a, fn_ra, lb_wa, lb_ra, sk_wa, sk_ra;
    logic           vs_wd;
    logic [VW-1:0]  fnw_d, lb_wd;
    logic [SW-1:0]  sk_wd;

    logic [VW-1:0] esrc_rd, etgt_rd, fnbr_rd, rnbr_rd, fin_rd, lab_rd;
    logic [EW-1:0] foff_rd, roff_rd;
    logic          vis_rd;
    logic [SW-1:0] stk_rd;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            esrc_mem[e_wa] <= e_wsrc;
            etgt_mem[e_wa] <= e_wtgt;
        end
        if (e_re)
        begin
            esrc_rd <= esrc_mem[e_ra];
            etgt_rd <= etgt_mem[e_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fo_we)
            foff_mem[fo_wa] <= fo_wd;
        if (fo_re)
            foff_rd <= foff_mem[fo_ra];
        if (ro_we)
            roff_mem[ro_wa] <= ro_wd;
        if (ro_re)
            roff_rd <= roff_mem[ro_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            fnbr_mem[fn_wa] <= fn_wd;
            rnbr_mem[rn_wa] <= rn_wd;
        end
        if (nb_re)
        begin
            fnbr_rd <= fnbr_mem[nb_ra];
            rnbr_rd <= rnbr_mem[nb_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vs_we)
            vis_mem[vs_wa] <= vs_wd;
        if (vs_re)
            vis_rd <= vis_mem[vs_ra];
        if (fn_we)
            fin_mem[fnw_a] <= fnw_d;
        if (fn_re)
            fin_rd <= fin_mem[fn_ra];
        if (lb_we)
            lab_mem[lb_wa] <= lb_wd;
        if (lb_re)
            lab_rd <= lab_mem[lb_ra];
        if (sk_we)
            stk_mem[sk_wa] <= sk_wd;
        if (sk_re)
            stk_rd <= stk_mem[sk_ra];
    end

    logic          a_ok, b_ok;
    logic [EW-1:0] off_sel;
    logic [VW-1:0] nbr_sel;
    logic [NW-1:0] v_plus;
    logic [VW-1:0] stk_v;

    assign a_ok    = (NW'(vertex_a) < n_total);
    assign b_ok    = (NW'(vertex_b) < n_total);
    assign off_sel = pass_reg ? roff_rd : foff_rd;
    assign nbr_sel = pass_reg ? rnbr_rd : fnbr_rd;
    assign stk_v   = stk_rd[SW-1:EW];
    assign v_plus  = NW'(cur_v_reg) + NW'(1);

    always_comb
    begin
        state_next = state_reg;   ec_next = ec_reg;       ready_next = ready_reg;
        pass_next = pass_reg;     e_idx_next = e_idx_reg; v_idx_next = v_idx_reg;
        fsum_next = fsum_reg;     rsum_next = rsum_reg;   fin_next = fin_reg;
        lbl_next = lbl_reg;       depth_next = depth_reg; root_next = root_reg;
        cur_v_next = cur_v_reg;   w_next = w_reg;         cur_pos_next = cur_pos_reg;
        cur_end_next = cur_end_reg; qa_next = qa_reg;     qb_next = qb_reg;
        la_next = la_reg;         done_next = 1'b0;       conn_next = 1'b0;
        status_next = status_reg;

        e_we = 1'b0; e_re = 1'b0; fo_we = 1'b0; fo_re = 1'b0; ro_we = 1'b0;
        ro_re = 1'b0; nb_we = 1'b0; nb_re = 1'b0; vs_we = 1'b0; vs_re = 1'b0;
        fn_we = 1'b0; fn_re = 1'b0; lb_we = 1'b0; lb_re = 1'b0; sk_we = 1'b0;
        sk_re = 1'b0;
        e_wa = ec_reg[EAW-1:0]; e_ra = e_idx_reg[EAW-1:0];
        e_wsrc = vertex_a; e_wtgt = vertex_b;
        fo_wa = NW'(esrc_rd); fo_ra = NW'(esrc_rd); fo_wd = foff_rd + EW'(1);
        ro_wa = NW'(etgt_rd); ro_ra = NW'(etgt_rd); ro_wd = roff_rd + EW'(1);
        fn_wa = EAW'(foff_rd - EW'(1)); rn_wa = EAW'(roff_rd - EW'(1));
        fn_wd = etgt_rd; rn_wd = esrc_rd; nb_ra = cur_pos_reg[EAW-1:0];
        vs_wa = v_idx_reg[VW-1:0]; vs_ra = v_idx_reg[VW-1:0]; vs_wd = 1'b0;
        fnw_a = fin_reg[VW-1:0]; fnw_d = cur_v_reg; fn_ra = VW'(v_idx_reg - NW'(1));
        lb_wa = root_reg; lb_wd = lbl_reg[VW-1:0]; lb_ra = qa_reg;
        sk_wa = VW'(depth_reg - NW'(1)); sk_wd = {cur_v_reg, cur_pos_reg};
        sk_ra = VW'(depth_reg - NW'(2));

        case (state_reg)
            S_IDLE:
            begin
                if (graph_clear)
                begin
                    ec_next = '0;
                    ready_next = 1'b0;
                end
                else if (start)
                begin
                    qa_next = vertex_a;
                    qb_next = vertex_b;
                    status_next = ST_OK;
                    case (mode)
                        MODE_ADD:
                        begin
                            done_next = 1'b1;
                            if (!a_ok || !b_ok)
                                status_next = ST_BAD_VERT;
                            else if (ec_reg == EW'(MAX_EDGES))
                                status_next = ST_FULL;
                            else
                            begin
                                e_we = 1'b1;
                                ec_next = ec_reg + EW'(1);
                                ready_next = 1'b0;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (!a_ok || !b_ok)
                            begin
                                done_next = 1'b1;
                                status_next = ST_BAD_VERT;
                            end
                            else if (ready_reg)
                                state_next = S_Q_RDA;
                            else
                            begin
                                v_idx_next = '0;
                                pass_next = 1'b0;
                                state_next = S_OCLR;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            done_next = 1'b1;
                            ec_next = '0;
                            ready_next = 1'b0;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            // zero both offset tables over 0..n
            S_OCLR:
            begin
                fo_we = 1'b1; ro_we = 1'b1;
                fo_wa = v_idx_reg; ro_wa = v_idx_reg; fo_wd = '0; ro_wd = '0;
                v_idx_next = v_idx_reg + NW'(1);
                if (v_idx_reg == n_total)
                begin
                    e_idx_next = '0;
                    v_idx_next = '0;
                    state_next = (ec_reg == '0) ? S_VCLR : S_CNT_RD;
                end
            end
            S_CNT_RD:
            begin
                e_re = 1'b1;
                state_next = S_CNT_OFF;
            end
            S_CNT_OFF:
            begin
                fo_re = 1'b1; ro_re = 1'b1;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                fo_we = 1'b1; ro_we = 1'b1;
                e_idx_next = e_idx_reg + EW'(1);
                state_next = S_CNT_RD;
                if (e_idx_reg == ec_reg - EW'(1))
                begin
                    v_idx_next = '0;
                    fsum_next = '0;
                    rsum_next = '0;
                    state_next = S_PFX_RD;
                end
            end
            S_PFX_RD:
            begin
                fo_re = 1'b1; ro_re = 1'b1;
                fo_ra = v_idx_reg; ro_ra = v_idx_reg;
                state_next = S_PFX_WR;
            end
            S_PFX_WR:
            begin
                fo_we = 1'b1; ro_we = 1'b1;
                fo_wa = v_idx_reg; ro_wa = v_idx_reg;
                fo_wd = fsum_reg + foff_rd; ro_wd = rsum_reg + roff_rd;
                fsum_next = fo_wd; rsum_next = ro_wd;
                v_idx_next = v_idx_reg + NW'(1);
                state_next = S_PFX_RD;
                if (v_idx_reg == n_total)
                begin
                    e_idx_next = ec_reg - EW'(1);
                    state_next = S_FIL_RD;
                end
            end
            // fill lists backwards so each list keeps insertion order
            S_FIL_RD:
            begin
                e_re = 1'b1;
                state_next = S_FIL_OFF;
            end
            S_FIL_OFF:
            begin
                fo_re = 1'b1; ro_re = 1'b1;
                state_next = S_FIL_WR;
            end
            S_FIL_WR:
            begin
                fo_we = 1'b1; ro_we = 1'b1; nb_we = 1'b1;
                fo_wd = foff_rd - EW'(1); ro_wd = roff_rd - EW'(1);
                e_idx_next = e_idx_reg - EW'(1);
                state_next = S_FIL_RD;
                if (e_idx_reg == '0)
                begin
                    v_idx_next = '0;
                    state_next = S_VCLR;
                end
            end
            S_VCLR:
            begin
                vs_we = 1'b1;
                v_idx_next = v_idx_reg + NW'(1);
                if (v_idx_reg == n_total - NW'(1))
                begin
                    v_idx_next = pass_reg ? fin_reg : '0;
                    fin_next = pass_reg ? fin_reg : '0;
                    lbl_next = '0;
                    state_next = S_SCAN;
                end
            end
            // outer loop: ascending vertices, then reverse finish order
            S_SCAN:
            begin
                if (!pass_reg)
                begin
                    if (v_idx_reg == n_total)
                    begin
                        pass_next = 1'b1;
                        v_idx_next = '0;
                        state_next = S_VCLR;
                    end
                    else
                    begin
                        vs_re = 1'b1;
                        root_next = v_idx_reg[VW-1:0];
                        state_next = S_SCHK;
                    end
                end
                else if (v_idx_reg == '0)
                begin
                    ready_next = 1'b1;
                    state_next = S_Q_RDA;
                end
                else
                begin
                    fn_re = 1'b1;
                    state_next = S_SFIN;
                end
            end
            S_SFIN:
            begin
                root_next = fin_rd;
                vs_re = 1'b1;
                vs_ra = fin_rd;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (vis_rd)
                begin
                    v_idx_next = pass_reg ? v_idx_reg - NW'(1) : v_idx_reg + NW'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    vs_we = 1'b1; vs_wa = root_reg; vs_wd = 1'b1;
                    lb_we = pass_reg;
                    cur_v_next = root_reg;
                    depth_next = NW'(1);
                    fo_re = 1'b1; ro_re = 1'b1;
                    fo_ra = NW'(root_reg); ro_ra = NW'(root_reg);
                    state_next = S_OFA;
                end
            end
            S_OFA:
            begin
                cur_pos_next = off_sel;
                fo_re = 1'b1; ro_re = 1'b1; fo_ra = v_plus; ro_ra = v_plus;
                state_next = S_OFB;
            end
            S_OFB:
            begin
                cur_end_next = off_sel;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (cur_pos_reg < cur_end_reg)
                begin
                    nb_re = 1'b1;
                    cur_pos_next = cur_pos_reg + EW'(1);
                    state_next = S_NBR;
                end
                else
                begin
                    if (!pass_reg && fin_reg < NW'(MAX_VERTICES))
                    begin
                        fn_we = 1'b1;
                        fin_next = fin_reg + NW'(1);
                    end
                    depth_next = depth_reg - NW'(1);
                    if (depth_reg == NW'(1))
                    begin
                        v_idx_next = pass_reg ? v_idx_reg - NW'(1) : v_idx_reg + NW'(1);
                        lbl_next = pass_reg ? lbl_reg + NW'(1) : lbl_reg;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        sk_re = 1'b1;
                        state_next = S_POP;
                    end
                end
            end
            S_NBR:
            begin
                w_next = nbr_sel;
                vs_re = 1'b1;
                vs_ra = nbr_sel;
                state_next = S_VIS;
            end
            S_VIS:
            begin
                state_next = S_STEP;
                if (!vis_rd && depth_reg < NW'(MAX_VERTICES))
                begin
                    vs_we = 1'b1; vs_wa = w_reg; vs_wd = 1'b1;
                    lb_we = pass_reg; lb_wa = w_reg;
                    sk_we = 1'b1;
                    cur_v_next = w_reg;
                    depth_next = depth_reg + NW'(1);
                    fo_re = 1'b1; ro_re = 1'b1; fo_ra = NW'(w_reg); ro_ra = NW'(w_reg);
                    state_next = S_OFA;
                end
            end
            S_POP:
            begin
                cur_v_next = stk_v;
                cur_pos_next = stk_rd[EW-1:0];
                fo_re = 1'b1; ro_re = 1'b1;
                fo_ra = NW'(stk_v) + NW'(1); ro_ra = NW'(stk_v) + NW'(1);
                state_next = S_OFB;
            end
            S_Q_RDA:
            begin
                lb_re = 1'b1;
                state_next = S_Q_RDB;
            end
            S_Q_RDB:
            begin
                la_next = lab_rd;
                lb_re = 1'b1;
                lb_ra = qb_reg;
                state_next = S_Q_CMP;
            end
            S_Q_CMP:
            begin
                done_next = 1'b1;
                conn_next = (la_reg == lab_rd);
                status_next = ST_OK;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ec_reg <= '0;
            ready_reg <= 1'b0;
            pass_reg <= 1'b0;
            done_reg <= 1'b0;
            conn_reg <= 1'b0;
            status_reg <= ST_OK;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ec_reg <= ec_next;
            ready_reg <= ready_next;
            pass_reg <= pass_next;
            done_reg <= done_next;
            conn_reg <= conn_next;
            status_reg <= status_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_idx_reg <= e_idx_next;   v_idx_reg <= v_idx_next;
        fsum_reg <= fsum_next;     rsum_reg <= rsum_next;
        fin_reg <= fin_next;       lbl_reg <= lbl_next;
        root_reg <= root_next;     cur_v_reg <= cur_v_next;
        w_reg <= w_next;           cur_pos_reg <= cur_pos_next;
        cur_end_reg <= cur_end_next;
        qa_reg <= qa_next;         qb_reg <= qb_next;
        la_reg <= la_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign connected = conn_reg;
    assign status    = status_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer busy");

    a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ec_reg <= EW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NW'(MAX_VERTICES))
        else $error("walk stack overflow");

    a_ready_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> state_reg == S_Q_RDA)
        else $error("labels marked ready outside a query");

endmodule

[rtl/strongly_connected_component_query.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongly_connected_component_query : SCC membership query (Kosaraju)
// Loads directed edges, labels components on the first query after a
// change, and answers whether two vertices share a component.
// ----------------------------------------------------------------------------
//  channel   | signals                                    | transfer
//  ----------+--------------------------------------------+-----------------
//  command   | start, busy, mode, vertex_a, vertex_b      | start & !busy
//  result    | done, connected, status                    | done (1 cycle)
//  config    | psel, penable, pwrite, paddr, pwdata,      | psel & penable &
//            | prdata, pready                             | pwrite & pready
//
//  Add, clear, unused-mode and bad-vertex items: result in the cycle after
//  the transfer, and a new command may follow at once.
//  Query with labels current: two label memory reads, then the compare.
//  Query after a change: clear the offset tables, count and sum the edges,
//  fill the lists, then per pass clear the visited marks and walk every
//  vertex and edge, then the query reads; each sequencer memory has one
//  read port and one write port.
//  Reset is asynchronous; no clearing pass is needed after it.
//  The result cannot be stalled: it is valid for the strobe cycle only.
// ----------------------------------------------------------------------------
module strongly_connected_component_query
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int NW = $clog2(MAX_VERTICES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [VW-1:0]      vertex_a,
    input  logic [VW-1:0]      vertex_b,
    // result
    output logic               done,
    output logic               connected,
    output logic [1:0]         status,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // clamped vertex count after reset
    localparam int NT_RESET = (NV_RESET > MAX_VERTICES) ? MAX_VERTICES : NV_RESET;

    logic [CFG_W-1:0] nv_reg, nv_next;
    logic [NW-1:0]    nt_reg, nt_next;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_NUM_VERT);
    assign prdata = (paddr[2] == REG_NUM_VERT) ? PDATA_W'(nv_reg) : '0;

    // zero acts as one vertex; above capacity acts as capacity
    always_comb
    begin
        nv_next = nv_reg;
        nt_next = nt_reg;
        if (cfg_we)
        begin
            nv_next = pwdata[CFG_W-1:0];
            if (pwdata[CFG_W-1:0] == '0)
                nt_next = NW'(1);
            else if (32'(pwdata[CFG_W-1:0]) > 32'(MAX_VERTICES))
                nt_next = NW'(MAX_VERTICES);
            else
                nt_next = NW'(pwdata[CFG_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= CFG_W'(NV_RESET);
            nt_reg <= NW'(NT_RESET);
        end
        else
        begin
            nv_reg <= nv_next;
            nt_reg <= nt_next;
        end
    end

    // a register write while the engine is idle also empties the graph
    scc_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .n_total     (nt_reg),
        .graph_clear (cfg_we),
        .busy        (busy),
        .done        (done),
        .connected   (connected),
        .status      (status)
    );

endmodule

[tb/scc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker : result predictor and comparator for the SCC query block
// Watches command, result and configuration transfers, keeps its own copy
// of the graph, labels components itself and checks every result in order.
// ----------------------------------------------------------------------------
module scc_checker
    import scc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic [9:0]         vertex_a,
    input  logic [9:0]         vertex_b,
    input  logic               done,
    input  logic               connected,
    input  logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 pending
);

    typedef struct packed {
        logic       connected;
        logic [1:0] status;
    } scc_answer_t;

    scc_answer_t answers_due[$];

    int vert_reg;
    int edge_src [DEF_MAX_EDGES];
    int edge_dst [DEF_MAX_EDGES];
    int edge_total;
    bit labels_valid;

    int fwd_off  [DEF_MAX_VERTICES+1];
    int rev_off  [DEF_MAX_VERTICES+1];
    int fwd_nbr  [DEF_MAX_EDGES];
    int rev_nbr  [DEF_MAX_EDGES];
    bit seen     [DEF_MAX_VERTICES];
    int finish_seq [DEF_MAX_VERTICES];
    int comp_id  [DEF_MAX_VERTICES];
    int stk_vert [DEF_MAX_VERTICES];
    int stk_pos  [DEF_MAX_VERTICES];

    // register value clamped to 1..MAX
    function automatic int live_vertices();
        if (vert_reg == 0)
            return 1;
        if (vert_reg > DEF_MAX_VERTICES)
            return DEF_MAX_VERTICES;
        return vert_reg;
    endfunction

    // adjacency in insertion order; rev swaps edge ends
    function automatic void build_adjacency(bit rev);
        int n, v, e, s, d;
        int off [DEF_MAX_VERTICES+1];
        n = live_vertices();
        for (v = 0; v <= n; v++)
            off[v] = 0;
        for (e = 0; e < edge_total; e++)
        begin
            s = rev ? edge_dst[e] : edge_src[e];
            d = rev ? edge_src[e] : edge_dst[e];
            if (s < n && d < n)
                off[s]++;
        end
        for (v = 1; v <= n; v++)
            off[v] += off[v-1];
        for (e = edge_total; e > 0; e--)
        begin
            s = rev ? edge_dst[e-1] : edge_src[e-1];
            d = rev ? edge_src[e-1] : edge_dst[e-1];
            if (s < n && d < n)
            begin
                off[s]--;
                if (rev)
                    rev_nbr[off[s]] = d;
                else
                    fwd_nbr[off[s]] = d;
            end
        end
        for (v = 0; v <= n; v++)
        begin
            if (rev)
                rev_off[v] = off[v];
            else
                fwd_off[v] = off[v];
        end
    endfunction

    // iterative DFS: postorder record on forward pass, labels on reverse pass
    function automatic void dfs_from(int root, bit rev, int label, ref int finished);
        int depth, v, w, lim;
        seen[root] = 1'b1;
        if (rev)
            comp_id[root] = label;
        stk_vert[0] = root;
        stk_pos[0]  = rev ? rev_off[root] : fwd_off[root];
        depth = 1;
        while (depth > 0)
        begin
            v   = stk_vert[depth-1];
            lim = rev ? rev_off[v+1] : fwd_off[v+1];
            if (stk_pos[depth-1] < lim)
            begin
                w = rev ? rev_nbr[stk_pos[depth-1]] : fwd_nbr[stk_pos[depth-1]];
                stk_pos[depth-1]++;
                if (w < DEF_MAX_VERTICES && !seen[w] && depth < DEF_MAX_VERTICES)
                begin
                    seen[w] = 1'b1;
                    if (rev)
                        comp_id[w] = label;
                    stk_vert[depth] = w;
                    stk_pos[depth]  = rev ? rev_off[w] : fwd_off[w];
                    depth++;
                end
            end
            else
            begin
                depth--;
                if (!rev && finished < DEF_MAX_VERTICES)
                begin
                    finish_seq[finished] = v;
                    finished++;
                end
            end
        end
    endfunction

    function automatic void label_components();
        int n, v, k, finished, label;
        n = live_vertices();
        finished = 0;
        label = 0;
        build_adjacency(1'b0);
        build_adjacency(1'b1);
        for (v = 0; v < n; v++)
            seen[v] = 1'b0;
        for (v = 0; v < n; v++)
            if (!seen[v])
                dfs_from(v, 1'b0, 0, finished);
        for (v = 0; v < n; v++)
            seen[v] = 1'b0;
        for (k = finished; k > 0; k--)
        begin
            if (!seen[finish_seq[k-1]])
            begin
                dfs_from(finish_seq[k-1], 1'b1, label, finished);
                label++;
            end
        end
        labels_valid = 1'b1;
    endfunction

    function automatic scc_answer_t predict_answer(logic [1:0] m, int a, int b);
        scc_answer_t ans;
        int n;
        n = live_vertices();
        ans = '0;
        ans.status = ST_OK;
        if (m == MODE_ADD)
        begin
            if (a >= n || b >= n)
                ans.status = ST_BAD_VERT;
            else if (edge_total >= DEF_MAX_EDGES)
                ans.status = ST_FULL;
            else
            begin
                edge_src[edge_total] = a;
                edge_dst[edge_total] = b;
                edge_total++;
                labels_valid = 1'b0;
            end
        end
        else if (m == MODE_QUERY)
        begin
            if (a >= n || b >= n)
                ans.status = ST_BAD_VERT;
            else
            begin
                if (!labels_valid)
                    label_components();
                ans.connected = (comp_id[a] == comp_id[b]);
            end
        end
        else if (m == MODE_CLEAR)
        begin
            edge_total   = 0;
            labels_valid = 1'b0;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scc_answer_t want;
        if (!rst_n)
        begin
            vert_reg     = NV_RESET;
            edge_total   = 0;
            labels_valid = 1'b0;
            mismatches   = 0;
            answers_due.delete();
            pending      = 0;
        end
        else
        begin
            // result first, so a transfer on the same edge queues behind it
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result with no transfer outstanding");
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (connected !== want.connected)
                    begin
                        $error("connected: expected %0d, got %0d", want.connected, connected);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == PADDR_W'(4 * REG_NUM_VERT))
            begin
                vert_reg     = int'(pwdata[CFG_W-1:0]);
                edge_total   = 0;
                labels_valid = 1'b0;
            end
            if (start && !busy)
                answers_due.insert(answers_due.size(),
                                   predict_answer(mode, vertex_a, vertex_b));
            pending = answers_due.size();
        end
    end

endmodule

[tb/strongly_connected_component_query_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongly_connected_component_query_tb : testbench top for the SCC block
// Drives edge, query and clear commands over a range of vertex counts,
// and leaves checking to scc_checker.
// ----------------------------------------------------------------------------
module strongly_connected_component_query_tb;
    import scc_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;
    localparam int RANDOM_ITEMS = 1600;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [9:0]         vertex_a;
    logic [9:0]         vertex_b;
    logic               done;
    logic               connected;
    logic [1:0]         status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int  mismatches;
    int  pending;
    int  cycle_count = 0;
    int  items_sent;
    int  queries_sent;
    int  random_sent;
    int  config_writes;
    int  live_n;          // vertex count the block is working with now
    bit  idle_on;         // random gaps between command transfers

    strongly_connected_component_query u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .done      (done),
        .connected (connected),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    scc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .vertex_a   (vertex_a),
        .vertex_b   (vertex_b),
        .done       (done),
        .connected  (connected),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
        clk = 1'b0;
    always
        #10 clk = ~clk;

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("strongly_connected_component_query_tb failed");
            $finish;
        end
    end

    // One command transfer. start is left high afterwards so back-to-back
    // items keep it asserted; it only drops for a gap, a register write or the end of the run.
    task automatic send_item(logic [1:0] m, int a, int b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        mode     <= m;
        vertex_a <= a[9:0];
        vertex_b <= b[9:0];
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (m == MODE_QUERY)
            queries_sent++;
    endtask

    // Register write only once the block has handed back every result.
    // Every item yields a result, so a short settle time is plenty.
    task automatic write_vertex_count(int value);
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * REG_NUM_VERT);
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        live_n = (value == 0) ? 1 : (value > DEF_MAX_VERTICES ? DEF_MAX_VERTICES : value);
        config_writes++;
    endtask

    // mostly in range, now and then anywhere in the 10-bit field
    function automatic int pick_vertex();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1023);
        return $urandom_range(0, live_n - 1);
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            send_item(MODE_ADD, pick_vertex(), pick_vertex());
        else if (r < 90)
            send_item(MODE_QUERY, pick_vertex(), pick_vertex());
        else if (r < 93)
            send_item(MODE_CLEAR, pick_vertex(), pick_vertex());
        else if (r < 95)
            send_item(2'd3, pick_vertex(), pick_vertex());
        else
            send_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                      $urandom_range(0, 1023));
        random_sent++;
    endtask

    initial
    begin
        int k, span, raw, pick;
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = MODE_ADD;
        vertex_a     = '0;
        vertex_b     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        items_sent   = 0;
        queries_sent = 0;
        random_sent  = 0;
        config_writes = 0;
        live_n       = NV_RESET;
        idle_on      = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset count, two-vertex cycle across the whole range
        send_item(MODE_ADD, 0, 1023);
        send_item(MODE_QUERY, 0, 1023);        // one-way only: separate
        send_item(MODE_ADD, 1023, 0);
        send_item(MODE_QUERY, 1023, 0);        // recomputed after the new edge
        send_item(MODE_QUERY, 1023, 1023);
        send_item(2'd3, 1023, 1023);           // unused mode is a no-op
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_QUERY, 0, 1023);
        // zero vertex count behaves as a single vertex
        write_vertex_count(0);
        send_item(MODE_ADD, 0, 1);
        send_item(MODE_ADD, 0, 0);
        send_item(MODE_QUERY, 1, 0);
        send_item(MODE_QUERY, 0, 0);
        // oversize count clamps to the maximum
        write_vertex_count(2047);
        send_item(MODE_ADD, 1023, 512);
        send_item(MODE_ADD, 512, 1023);
        send_item(MODE_QUERY, 512, 1023);
        write_vertex_count(1);
        send_item(MODE_QUERY, 0, 0);
        // a write empties the graph even at the same count
        write_vertex_count(3);
        send_item(MODE_ADD, 0, 1);
        send_item(MODE_ADD, 1, 2);
        send_item(MODE_ADD, 2, 0);
        send_item(MODE_QUERY, 0, 2);
        write_vertex_count(3);
        send_item(MODE_QUERY, 0, 2);

        // small dense graph with a bad vertex among the edges
        write_vertex_count(8);
        for (k = 0; k < 12; k++)
            send_item(MODE_ADD, $urandom_range(0, 7), $urandom_range(0, 7));
        send_item(MODE_ADD, 9, 1);             // vertex beyond the count
        for (k = 0; k < 6; k++)
            send_item(MODE_QUERY, $urandom_range(0, 7), $urandom_range(0, 7));

        // random phases over a spread of vertex counts
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                raw = 0;
            else if (pick == 1)
                raw = 1;
            else if (pick == 2)
                raw = 1024;
            else if (pick == 3)
                raw = 2047 - $urandom_range(0, 1) * 1000;
            else
                raw = $urandom_range(2, 40);
            write_vertex_count(raw);
            span = $urandom_range(20, 80);
            for (k = 0; k < span && random_sent < RANDOM_ITEMS; k++)
            begin
                idle_on = (random_sent < RANDOM_ITEMS - 200);
                random_item();
            end
        end
        start <= 1'b0;

        // drain
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d commands (%0d queries, %0d random) over %0d vertex count settings",
                 items_sent, queries_sent, random_sent, config_writes);
        $display("clamped counts, bad vertices, clears and unused modes included");
        if (mismatches == 0 && pending == 0)
            $display("strongly_connected_component_query_tb passed");
        else
            $display("strongly_connected_component_query_tb failed");
        $finish;
    end

endmodule

[sim.f]
rtl/scc_pkg.sv
rtl/scc_engine.sv
rtl/strongly_connected_component_query.sv
tb/scc_checker.sv
tb/strongly_connected_component_query_tb.sv
